// File: rtl/assert_macros.svh
// assertion macros used by two_opt_tour_improver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/tour_pkg.sv
// ----------------------------------------------------------------------------
// tour_pkg: shared types and constants of the 2-opt tour improver
// opcodes, sequencer states and default sizes
// ----------------------------------------------------------------------------
package tour_pkg;

  localparam int unsigned MaxCitiesDef = 64;
  localparam int unsigned DistBitsDef  = 16;
  localparam int unsigned CityW        = 6;
  localparam int unsigned CountW       = 7;
  localparam int unsigned LenW         = 22;
  localparam int unsigned PassLimit    = 1024;
  localparam int unsigned PassW        = 11;
  localparam logic [LenW-1:0] LenMax   = '1;

  typedef enum logic [1:0] {
    OP_DIST = 2'd0,
    OP_TOUR = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PASS,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_DA,
    ST_DB,
    ST_DC,
    ST_DD,
    ST_CMP,
    ST_SW_RD,
    ST_SW_WAIT,
    ST_SW_WR,
    ST_SW_WR2,
    ST_NEXT,
    ST_M_RD,
    ST_M_WAIT,
    ST_M_D,
    ST_M_ACC,
    ST_E_RD,
    ST_E_WAIT,
    ST_E_OUT
  } state_e;

endpackage

// File: rtl/tour_ram.sv
// ----------------------------------------------------------------------------
// tour_ram: generic single port ram
// one write or one read per cycle, registered read data
// ----------------------------------------------------------------------------
module tour_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/two_opt_tour_improver.sv
// ----------------------------------------------------------------------------
// two_opt_tour_improver: 2-opt local search over a loaded tour
// distance matrix and tour in rams, a sequencer runs the passes
// ----------------------------------------------------------------------------
// Load transactions (distance entry, tour position) go into the rams while
// idle. A run steps a sequencer over the two rams: per (u,v) candidate four
// tour reads, four distance reads, a compare and a step; per swapped pair of
// a reversal two tour reads and two writes. A pass covers (n-2)*(n-3)/2
// candidates. Measuring the length takes two tour reads, a distance read and
// a sum per city, emission a tour read and an output per city, held on stall.
// Up to 1024 passes are run. Input is stalled for the whole run.
`include "assert_macros.svh"

module two_opt_tour_improver #(
  parameter int unsigned MAX_CITIES = tour_pkg::MaxCitiesDef,
  parameter int unsigned DIST_BITS  = tour_pkg::DistBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  row_or_position_i,
  input  logic [5:0]  column_i,
  input  logic [15:0] distance_i,
  input  logic [5:0]  city_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  position_o,
  output logic [5:0]  tour_city_o,
  output logic [21:0] tour_length_o,
  output logic        last_o
);

  localparam int unsigned IdxW  = $clog2(MAX_CITIES);
  localparam int unsigned DAddW = 2 * IdxW;
  localparam int unsigned DW    = DIST_BITS;
  localparam int unsigned LW    = tour_pkg::LenW;
  localparam int unsigned SW    = ((DW > LW) ? DW : LW) + 1;
  localparam logic [IdxW-1:0] IdxOne = IdxW'(1);
  localparam logic [IdxW-1:0] IdxTwo = IdxW'(2);

  tour_pkg::state_e state_q, state_d;

  logic [tour_pkg::CountW-1:0] cnt_q;
  logic [IdxW-1:0] n_m1, u_q, u_d, v_q, v_d, lo_q, lo_d, hi_q, hi_d, i_q, i_d;
  logic [5:0] ca_q, cb_q, cc_q, cd_q, cl_q;
  logic [DW-1:0] da_q, db_q, dc_q, dd_v, meas_v;
  logic ok_a_q, ok_b_q, ok_c_q, ok_d_q;
  logic pass_chg_q, pass_chg_d;
  logic [tour_pkg::PassW-1:0] passes_q, passes_d;
  logic [LW-1:0] len_q, len_d, out_len_q;
  logic [5:0] tour_city_q;
  logic [IdxW-1:0] pos_q;
  logic last_q, out_valid_q;

  // ram ports
  logic t_we, d_we;
  logic [IdxW-1:0] t_addr;
  logic [5:0] t_wdata, t_rdata;
  logic [DAddW-1:0] d_addr;
  logic [DW-1:0] d_rdata;

  logic in_acc, out_acc, idle, emit, pass_done;
  tour_pkg::opcode_e op;
  logic [6:0] n_eff;
  logic [DW:0] gain, cost;
  logic [SW-1:0] len_sum;

  assign op      = tour_pkg::opcode_e'(opcode_i);
  assign idle    = (state_q == tour_pkg::ST_IDLE);
  assign in_stall_o = !idle;
  assign in_acc  = in_valid_i && idle;
  assign out_acc = out_valid_q && !out_stall_i;
  assign emit    = out_acc || !out_valid_q;

  always_comb begin
    n_eff = cnt_q;
    if (cnt_q < 7'd3) n_eff = 7'd3;
    if ({25'd0, cnt_q} > MAX_CITIES) n_eff = 7'(MAX_CITIES);
  end
  assign n_m1 = IdxW'(n_eff - 7'd1);

  assign pass_done = (n_eff == 7'd3) || !pass_chg_q ||
                     (passes_q == tour_pkg::PassW'(tour_pkg::PassLimit));

  // distance lookup address, out of range cities read as zero
  function automatic logic in_rng(input logic [5:0] c);
    return {26'd0, c} < MAX_CITIES;
  endfunction

  tour_ram #(.Width(6), .Depth(MAX_CITIES)) u_tour (
    .clk_i(clk_i), .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wdata), .rdata_o(t_rdata)
  );
  tour_ram #(.Width(DW), .Depth(2 ** DAddW)) u_dist (
    .clk_i(clk_i), .we_i(d_we), .addr_i(d_addr), .wdata_i(DW'(distance_i)),
    .rdata_o(d_rdata)
  );

  // the fourth distance and each measured edge are used straight off the ram
  assign dd_v   = ok_d_q ? d_rdata : '0;
  assign meas_v = ok_a_q ? d_rdata : '0;
  assign gain = {1'b0, da_q} + {1'b0, db_q};
  assign cost = {1'b0, dc_q} + {1'b0, dd_v};
  assign len_sum = SW'(len_q) + SW'(meas_v);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tour_pkg::ST_IDLE:    if (in_acc && op == tour_pkg::OP_RUN) state_d = tour_pkg::ST_PASS;
      tour_pkg::ST_PASS:    state_d = pass_done ? tour_pkg::ST_M_RD : tour_pkg::ST_RD_A;
      tour_pkg::ST_RD_A:    state_d = tour_pkg::ST_RD_B;
      tour_pkg::ST_RD_B:    state_d = tour_pkg::ST_RD_C;
      tour_pkg::ST_RD_C:    state_d = tour_pkg::ST_RD_D;
      tour_pkg::ST_RD_D:    state_d = tour_pkg::ST_DA;
      tour_pkg::ST_DA:      state_d = tour_pkg::ST_DB;
      tour_pkg::ST_DB:      state_d = tour_pkg::ST_DC;
      tour_pkg::ST_DC:      state_d = tour_pkg::ST_DD;
      tour_pkg::ST_DD:      state_d = tour_pkg::ST_CMP;
      tour_pkg::ST_CMP:     state_d = (gain < cost) ? tour_pkg::ST_SW_RD : tour_pkg::ST_NEXT;
      tour_pkg::ST_SW_RD:   state_d = tour_pkg::ST_SW_WAIT;
      tour_pkg::ST_SW_WAIT: state_d = tour_pkg::ST_SW_WR;
      tour_pkg::ST_SW_WR:   state_d = tour_pkg::ST_SW_WR2;
      tour_pkg::ST_SW_WR2:
        state_d = (lo_q + IdxOne < hi_q - IdxOne) ? tour_pkg::ST_SW_RD : tour_pkg::ST_NEXT;
      tour_pkg::ST_NEXT: begin
        if (v_q == n_m1 - IdxOne && u_q == n_m1 - IdxTwo) state_d = tour_pkg::ST_PASS;
        else state_d = tour_pkg::ST_RD_A;
      end
      tour_pkg::ST_M_RD:    state_d = tour_pkg::ST_M_WAIT;
      tour_pkg::ST_M_WAIT:  state_d = tour_pkg::ST_M_D;
      tour_pkg::ST_M_D:     state_d = tour_pkg::ST_M_ACC;
      tour_pkg::ST_M_ACC:   state_d = (i_q == n_m1) ? tour_pkg::ST_E_RD : tour_pkg::ST_M_RD;
      tour_pkg::ST_E_RD:    state_d = tour_pkg::ST_E_WAIT;
      tour_pkg::ST_E_WAIT:  state_d = tour_pkg::ST_E_OUT;
      tour_pkg::ST_E_OUT: begin
        if (emit) state_d = (i_q == n_m1) ? tour_pkg::ST_IDLE : tour_pkg::ST_E_RD;
      end
      default:              state_d = tour_pkg::ST_IDLE;
    endcase
  end

  // ram addressing and datapath
  always_comb begin
    t_we = 1'b0; t_addr = '0; t_wdata = '0; d_we = 1'b0; d_addr = '0;
    u_d = u_q; v_d = v_q; lo_d = lo_q; hi_d = hi_q; i_d = i_q;
    pass_chg_d = pass_chg_q; passes_d = passes_q; len_d = len_q;
    unique case (state_q)
      tour_pkg::ST_IDLE: begin
        if (in_acc && op == tour_pkg::OP_DIST) begin
          d_we = in_rng(row_or_position_i) && in_rng(column_i);
          d_addr = {IdxW'(row_or_position_i), IdxW'(column_i)};
        end
        if (in_acc && op == tour_pkg::OP_TOUR) begin
          t_we = in_rng(row_or_position_i);
          t_addr = IdxW'(row_or_position_i);
          t_wdata = city_i;
        end
        pass_chg_d = 1'b1; passes_d = '0;
      end
      tour_pkg::ST_PASS: begin
        if (!pass_done) begin
          pass_chg_d = 1'b0; passes_d = passes_q + tour_pkg::PassW'(1);
        end
        u_d = IdxOne; v_d = IdxTwo;
        i_d = '0; len_d = '0;
      end
      tour_pkg::ST_RD_A: t_addr = u_q - IdxOne;
      tour_pkg::ST_RD_B: t_addr = u_q;
      tour_pkg::ST_RD_C: t_addr = v_q;
      tour_pkg::ST_RD_D: t_addr = v_q + IdxOne;
      // gain: d[u][v+1], d[u-1][v]; cost: d[u][u-1], d[v][v+1]
      tour_pkg::ST_DA: d_addr = {IdxW'(cb_q), IdxW'(t_rdata)};
      tour_pkg::ST_DB: d_addr = {IdxW'(ca_q), IdxW'(cc_q)};
      tour_pkg::ST_DC: d_addr = {IdxW'(cb_q), IdxW'(ca_q)};
      tour_pkg::ST_DD: d_addr = {IdxW'(cc_q), IdxW'(cd_q)};
      tour_pkg::ST_CMP: begin
        lo_d = u_q; hi_d = v_q;
        if (gain < cost) pass_chg_d = 1'b1;
      end
      tour_pkg::ST_SW_RD:   t_addr = lo_q;
      tour_pkg::ST_SW_WAIT: t_addr = hi_q;
      tour_pkg::ST_SW_WR: begin
        // ca holds tour[lo], t_rdata is tour[hi]
        t_we = 1'b1; t_addr = lo_q; t_wdata = t_rdata;
      end
      tour_pkg::ST_SW_WR2: begin
        t_we = 1'b1; t_addr = hi_q; t_wdata = ca_q;
        lo_d = lo_q + IdxOne; hi_d = hi_q - IdxOne;
      end
      tour_pkg::ST_NEXT: begin
        if (v_q == n_m1 - IdxOne) begin
          u_d = u_q + IdxOne; v_d = u_q + IdxTwo;
        end else v_d = v_q + IdxOne;
      end
      tour_pkg::ST_M_RD:   t_addr = (i_q == '0) ? n_m1 : i_q - IdxOne;
      tour_pkg::ST_M_WAIT: t_addr = i_q;
      // closing edge runs from the first city to the last
      tour_pkg::ST_M_D: begin
        if (i_q == '0) d_addr = {IdxW'(t_rdata), IdxW'(ca_q)};
        else d_addr = {IdxW'(ca_q), IdxW'(t_rdata)};
      end
      tour_pkg::ST_M_ACC: begin
        len_d = (len_sum > SW'(tour_pkg::LenMax)) ? tour_pkg::LenMax : len_sum[LW-1:0];
        i_d = (i_q == n_m1) ? '0 : i_q + IdxOne;
      end
      tour_pkg::ST_E_RD: t_addr = i_q;
      tour_pkg::ST_E_OUT: begin
        if (emit) i_d = (i_q == n_m1) ? '0 : i_q + IdxOne;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tour_pkg::ST_IDLE;
      cnt_q <= 7'd64;
      pass_chg_q <= 1'b0;
      passes_q <= '0;
      len_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      pass_chg_q <= pass_chg_d;
      passes_q <= passes_d;
      len_q <= len_d;
      if (state_q == tour_pkg::ST_E_OUT && emit) out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;
    end
  end

  // payload regs; pending tour writes are in the ram before reads
  always_ff @(posedge clk_i) begin
    u_q <= u_d; v_q <= v_d; lo_q <= lo_d; hi_q <= hi_d; i_q <= i_d;
    unique case (state_q)
      tour_pkg::ST_RD_B: ca_q <= t_rdata;
      tour_pkg::ST_RD_C: cb_q <= t_rdata;
      tour_pkg::ST_RD_D: cc_q <= t_rdata;
      tour_pkg::ST_DA: begin
        cd_q <= t_rdata;
        ok_a_q <= in_rng(cb_q) && in_rng(t_rdata);
      end
      tour_pkg::ST_DB: begin
        da_q <= ok_a_q ? d_rdata : '0;
        ok_b_q <= in_rng(ca_q) && in_rng(cc_q);
      end
      tour_pkg::ST_DC: begin
        db_q <= ok_b_q ? d_rdata : '0;
        ok_c_q <= in_rng(cb_q) && in_rng(ca_q);
      end
      tour_pkg::ST_DD: begin
        dc_q <= ok_c_q ? d_rdata : '0;
        ok_d_q <= in_rng(cc_q) && in_rng(cd_q);
      end
      tour_pkg::ST_SW_WAIT: ca_q <= t_rdata;
      tour_pkg::ST_M_WAIT:  ca_q <= t_rdata;
      tour_pkg::ST_M_D:     ok_a_q <= in_rng(ca_q) && in_rng(t_rdata);
      tour_pkg::ST_E_WAIT:  cl_q <= t_rdata;
      tour_pkg::ST_E_OUT: begin
        if (emit) begin
          tour_city_q <= cl_q;
          pos_q <= i_q;
          last_q <= (i_q == n_m1);
          out_len_q <= len_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign position_o    = 6'(pos_q);
  assign tour_city_o   = tour_city_q;
  assign tour_length_o = out_len_q;
  assign last_o        = last_q;

  `ASSERT_NEVER(a_no_in_busy, clk_i, rst_ni, in_acc && !idle)
  `ASSERT_IMPL(a_pass_limit, clk_i, rst_ni, passes_q <= tour_pkg::PassW'(tour_pkg::PassLimit))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i |=> out_valid_q)
  `ASSERT_IMPL(a_pos_hold, clk_i, rst_ni, out_valid_q && out_stall_i |=> $stable(pos_q))
  `ASSERT_IMPL(a_len_hold, clk_i, rst_ni, out_valid_q && out_stall_i |=> $stable(out_len_q))

endmodule
